// File: design/cspsc_pkg.sv
// Package: constants, payload types and address helper of the chunked queue.
package cspsc_pkg;

   localparam int CHUNK_DEPTH = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int BANK_COUNT  = 3;

   localparam int BANK_W = 2;
   localparam int FILL_W = $clog2(CHUNK_DEPTH + 1);
   localparam int POS_W  = $clog2(CHUNK_DEPTH);
   localparam int STORE_DEPTH = BANK_COUNT * CHUNK_DEPTH;
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   localparam logic [1:0] OP_PRODUCE = 2'd0;
   localparam logic [1:0] OP_FLUSH   = 2'd1;
   localparam logic [1:0] OP_CONSUME = 2'd2;

   localparam logic [1:0] ST_DONE       = 2'd0;
   localparam logic [1:0] ST_PROD_BLOCK = 2'd1;
   localparam logic [1:0] ST_CONS_BLOCK = 2'd2;

   localparam logic [BANK_W-1:0] PRODUCER_BANK_RESET = BANK_W'(0);
   localparam logic [BANK_W-1:0] HANDOFF_BANK_RESET  = BANK_W'(1);
   localparam logic [BANK_W-1:0] CONSUMER_BANK_RESET = BANK_W'(2);

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(CHUNK_DEPTH);

   typedef struct packed {
      logic [1:0]             op;
      logic [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [VALUE_WIDTH-1:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        status;
   } cmd_type;

   function automatic logic [ADDR_W-1:0] slot_addr(logic [BANK_W-1:0] bank,
                                                   logic [POS_W-1:0] pos);
      return ADDR_W'(bank * CHUNK_DEPTH) + ADDR_W'(pos);
   endfunction

endpackage

// File: design/cspsc_ram.sv
// Generic single-port synchronous RAM with registered read data.
module cspsc_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 192,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/cspsc_ctrl.sv
// Bank rotation and fill tracking; issues at most one store access per request.
module cspsc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          op,
   output cspsc_pkg::cmd_type  cmd
);

   logic [cspsc_pkg::BANK_W-1:0] pbank_ff, pbank_in;
   logic [cspsc_pkg::BANK_W-1:0] hbank_ff, hbank_in;
   logic [cspsc_pkg::BANK_W-1:0] cbank_ff, cbank_in;
   logic [cspsc_pkg::FILL_W-1:0] pfill_ff, pfill_in;
   logic [cspsc_pkg::FILL_W-1:0] hfill_ff, hfill_in;
   logic [cspsc_pkg::FILL_W-1:0] cfill_ff, cfill_in;
   logic [cspsc_pkg::FILL_W-1:0] cpos_ff, cpos_in;
   logic                         hfull_ff, hfull_in;
   logic [cspsc_pkg::BANK_W-1:0] swap;

   always_comb begin
      pbank_in = pbank_ff;
      hbank_in = hbank_ff;
      cbank_in = cbank_ff;
      pfill_in = pfill_ff;
      hfill_in = hfill_ff;
      cfill_in = cfill_ff;
      cpos_in  = cpos_ff;
      hfull_in = hfull_ff;
      swap     = hbank_ff;
      cmd.wr_en  = 1'b0;
      cmd.rd_en  = 1'b0;
      cmd.addr   = cspsc_pkg::slot_addr(pbank_ff, pfill_ff[cspsc_pkg::POS_W-1:0]);
      cmd.status = cspsc_pkg::ST_DONE;

      case (op)
         cspsc_pkg::OP_PRODUCE: begin
            if (pfill_ff >= cspsc_pkg::FILL_FULL) begin
               cmd.status = cspsc_pkg::ST_PROD_BLOCK;
            end else begin
               cmd.wr_en = accept;
               pfill_in  = pfill_ff + 1'b1;
            end
         end
         cspsc_pkg::OP_FLUSH: begin
            if (pfill_ff != '0) begin
               if (hfull_ff) begin
                  cmd.status = cspsc_pkg::ST_PROD_BLOCK;
               end else begin
                  swap     = hbank_in;
                  hbank_in = pbank_in;
                  pbank_in = swap;
                  hfill_in = pfill_in;
                  hfull_in = 1'b1;
                  pfill_in = '0;
               end
            end
         end
         cspsc_pkg::OP_CONSUME: begin
            if (cpos_ff < cfill_ff) begin
               cmd.rd_en = accept;
               cmd.addr  = cspsc_pkg::slot_addr(cbank_ff, cpos_ff[cspsc_pkg::POS_W-1:0]);
               cpos_in   = cpos_ff + 1'b1;
            end else if (hfull_ff) begin
               cmd.rd_en = accept;
               cmd.addr  = cspsc_pkg::slot_addr(hbank_ff, '0);
               cbank_in  = hbank_ff;
               hbank_in  = cbank_ff;
               cfill_in  = hfill_ff;
               hfull_in  = 1'b0;
               hfill_in  = '0;
               cpos_in   = cspsc_pkg::FILL_W'(1);
            end else begin
               cmd.status = cspsc_pkg::ST_CONS_BLOCK;
            end
         end
         default: begin
         end
      endcase

      // move a pending full chunk once the slot is free
      if (pfill_in >= cspsc_pkg::FILL_FULL && !hfull_in) begin
         swap     = hbank_in;
         hbank_in = pbank_in;
         pbank_in = swap;
         hfill_in = pfill_in;
         hfull_in = 1'b1;
         pfill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pbank_ff <= cspsc_pkg::PRODUCER_BANK_RESET;
         hbank_ff <= cspsc_pkg::HANDOFF_BANK_RESET;
         cbank_ff <= cspsc_pkg::CONSUMER_BANK_RESET;
         pfill_ff <= '0;
         hfill_ff <= '0;
         cfill_ff <= '0;
         cpos_ff  <= '0;
         hfull_ff <= 1'b0;
      end else if (accept) begin
         pbank_ff <= pbank_in;
         hbank_ff <= hbank_in;
         cbank_ff <= cbank_in;
         pfill_ff <= pfill_in;
         hfill_ff <= hfill_in;
         cfill_ff <= cfill_in;
         cpos_ff  <= cpos_in;
         hfull_ff <= hfull_in;
      end
   end

endmodule

// File: design/chunked_spsc_queue.sv
// Top level: chunked single-producer single-consumer queue with request/response channels.
// An accepted request waits in the pending register until the response register is free.
// Throughput: one request per cycle while the response side keeps taking results.
// The chunk store is one single-port RAM; each request makes at most one access to it.
// Reset restores the bank indexes and clears fill counts and the handshake state.
// Store contents are not cleared; only entries already written are ever read.
module chunked_spsc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cspsc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cspsc_pkg::rsp_type rsp_data
);

   cspsc_pkg::cmd_type                cmd;
   logic [cspsc_pkg::VALUE_WIDTH-1:0] rd_data;
   logic                              accept;
   logic                              out_free;
   logic                              load;

   logic                              pend_ff, pend_in;
   logic [1:0]                        pend_status_ff;
   logic                              pend_rd_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   cspsc_pkg::rsp_type                rsp_data_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = pend_ff && out_free;
   assign req_ready = !pend_ff || out_free;
   assign accept    = req_valid && req_ready;

   cspsc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .op     (req_data.op),
      .cmd    (cmd)
   );

   cspsc_ram #(
      .DATA_W (cspsc_pkg::VALUE_WIDTH),
      .DEPTH  (cspsc_pkg::STORE_DEPTH),
      .ADDR_W (cspsc_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .rd_en   (cmd.rd_en),
      .addr    (cmd.addr),
      .wr_data (req_data.value),
      .rd_data (rd_data)
   );

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (load) begin
         pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= cmd.status;
         pend_rd_ff     <= cmd.rd_en;
      end
      if (load) begin
         rsp_data_ff.status     <= pend_status_ff;
         rsp_data_ff.read_value <= pend_rd_ff ? rd_data : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: tb/tb_chunked_spsc_queue.sv
// Testbench: chunked SPSC queue, directed table plus random traffic against a bank-level predictor.
module tb_chunked_spsc_queue;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_ITEMS = 1300 - DIRECTED_COUNT;
   localparam int BURST_LEN = 2 * cspsc_pkg::CHUNK_DEPTH + 8;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [1:0]                        op;
      logic [cspsc_pkg::VALUE_WIDTH-1:0] value;
      bit                                typed;
      logic [1:0]                        status;
      logic [cspsc_pkg::VALUE_WIDTH-1:0] read_value;
   } step_row_type;

   typedef struct {
      cspsc_pkg::req_type request;
      bit                 typed;
      cspsc_pkg::rsp_type typed_rsp;
   } pending_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   cspsc_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   cspsc_pkg::rsp_type rsp_data;

   pending_entry_type  pending_reqs[$];
   cspsc_pkg::rsp_type expected_rsps[$];
   int                 error_count = 0;
   bit                 req_fast = 1'b0;
   bit                 rsp_fast = 1'b0;

   logic [cspsc_pkg::VALUE_WIDTH-1:0] shadow_store [cspsc_pkg::STORE_DEPTH];
   logic [cspsc_pkg::BANK_W-1:0]      prod_bank = cspsc_pkg::PRODUCER_BANK_RESET;
   logic [cspsc_pkg::BANK_W-1:0]      hand_bank = cspsc_pkg::HANDOFF_BANK_RESET;
   logic [cspsc_pkg::BANK_W-1:0]      cons_bank = cspsc_pkg::CONSUMER_BANK_RESET;
   logic [cspsc_pkg::FILL_W-1:0]      prod_fill = '0;
   logic                              hand_full = 1'b0;
   logic [cspsc_pkg::FILL_W-1:0]      hand_fill = '0;
   logic [cspsc_pkg::FILL_W-1:0]      cons_fill = '0;
   logic [cspsc_pkg::FILL_W-1:0]      cons_pos = '0;

   step_row_type directed_steps [DIRECTED_COUNT] = '{
      '{cspsc_pkg::OP_CONSUME, 32'h0000_0000, 1'b1, cspsc_pkg::ST_CONS_BLOCK, 32'h0000_0000},
      '{cspsc_pkg::OP_FLUSH,   32'h0000_0000, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{OP_UNUSED,             32'hFFFF_FFFF, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_PRODUCE, 32'h0000_0000, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_PRODUCE, 32'hFFFF_FFFF, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_PRODUCE, 32'hAAAA_AAAA, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_PRODUCE, 32'h5555_5555, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_CONSUME, 32'h0000_0000, 1'b1, cspsc_pkg::ST_CONS_BLOCK, 32'h0000_0000},
      '{cspsc_pkg::OP_FLUSH,   32'hFFFF_FFFF, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_PRODUCE, 32'h8000_0000, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_FLUSH,   32'h0000_0000, 1'b1, cspsc_pkg::ST_PROD_BLOCK, 32'h0000_0000},
      '{cspsc_pkg::OP_CONSUME, 32'hFFFF_FFFF, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_CONSUME, 32'h0000_0000, 1'b1, cspsc_pkg::ST_DONE,       32'hFFFF_FFFF},
      '{cspsc_pkg::OP_CONSUME, 32'h0000_0000, 1'b1, cspsc_pkg::ST_DONE,       32'hAAAA_AAAA},
      '{cspsc_pkg::OP_CONSUME, 32'h0000_0000, 1'b1, cspsc_pkg::ST_DONE,       32'h5555_5555},
      '{cspsc_pkg::OP_FLUSH,   32'h0000_0000, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_CONSUME, 32'h0000_0000, 1'b1, cspsc_pkg::ST_DONE,       32'h8000_0000},
      '{cspsc_pkg::OP_CONSUME, 32'h0000_0000, 1'b1, cspsc_pkg::ST_CONS_BLOCK, 32'h0000_0000},
      '{cspsc_pkg::OP_PRODUCE, 32'h0000_0001, 1'b0, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{OP_UNUSED,             32'h0000_0000, 1'b1, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_FLUSH,   32'h0000_0000, 1'b0, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_CONSUME, 32'h0000_0000, 1'b0, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_PRODUCE, 32'h7FFF_FFFF, 1'b0, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_FLUSH,   32'h0000_0000, 1'b0, cspsc_pkg::ST_DONE,       32'h0000_0000},
      '{cspsc_pkg::OP_CONSUME, 32'h0000_0000, 1'b0, cspsc_pkg::ST_DONE,       32'h0000_0000}
   };

   chunked_spsc_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void hand_off_chunk();
      logic [cspsc_pkg::BANK_W-1:0] swap_bank;
      swap_bank = hand_bank;
      hand_bank = prod_bank;
      prod_bank = swap_bank;
      hand_fill = prod_fill;
      hand_full = 1'b1;
      prod_fill = '0;
   endfunction

   function automatic cspsc_pkg::rsp_type predict_queue_step(cspsc_pkg::req_type request);
      cspsc_pkg::rsp_type           result;
      logic [cspsc_pkg::BANK_W-1:0] swap_bank;
      result.status = cspsc_pkg::ST_DONE;
      result.read_value = '0;
      case (request.op)
         cspsc_pkg::OP_PRODUCE: begin
            if (prod_fill >= cspsc_pkg::FILL_FULL) begin
               result.status = cspsc_pkg::ST_PROD_BLOCK;
            end else begin
               shadow_store[int'(prod_bank) * cspsc_pkg::CHUNK_DEPTH + int'(prod_fill)] =
                  request.value;
               prod_fill = prod_fill + 1'b1;
               if (prod_fill == cspsc_pkg::FILL_FULL && !hand_full) hand_off_chunk();
            end
         end
         cspsc_pkg::OP_FLUSH: begin
            if (prod_fill != 0) begin
               if (hand_full) result.status = cspsc_pkg::ST_PROD_BLOCK;
               else hand_off_chunk();
            end
         end
         cspsc_pkg::OP_CONSUME: begin
            if (cons_pos < cons_fill) begin
               result.read_value =
                  shadow_store[int'(cons_bank) * cspsc_pkg::CHUNK_DEPTH + int'(cons_pos)];
               cons_pos = cons_pos + 1'b1;
            end else if (hand_full) begin
               swap_bank = cons_bank;
               cons_bank = hand_bank;
               hand_bank = swap_bank;
               cons_fill = hand_fill;
               hand_full = 1'b0;
               hand_fill = '0;
               result.read_value = shadow_store[int'(cons_bank) * cspsc_pkg::CHUNK_DEPTH];
               cons_pos = cspsc_pkg::FILL_W'(1);
            end else begin
               result.status = cspsc_pkg::ST_CONS_BLOCK;
            end
         end
         default: ;
      endcase
      // advance a pending full chunk once the slot frees up
      if (prod_fill >= cspsc_pkg::FILL_FULL && !hand_full) hand_off_chunk();
      return result;
   endfunction

   task automatic report_mismatch(string field, logic [cspsc_pkg::VALUE_WIDTH-1:0] got,
                                  logic [cspsc_pkg::VALUE_WIDTH-1:0] want);
      $display("mismatch at %0t: %s got %h, expected %h", $time, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      pending_entry_type  entry;
      cspsc_pkg::rsp_type predicted;
      cspsc_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            entry = pending_reqs.pop_front();
            predicted = predict_queue_step(entry.request);
            expected_rsps.push_back(entry.typed ? entry.typed_rsp : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response, read_value", rsp_data.read_value, '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", cspsc_pkg::VALUE_WIDTH'(rsp_data.status),
                                  cspsc_pkg::VALUE_WIDTH'(want.status));
               if (rsp_data.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_data.read_value, want.read_value);
            end
         end
      end
   end

   task automatic send_request(cspsc_pkg::req_type request, bit typed,
                               cspsc_pkg::rsp_type typed_rsp);
      int                gap;
      pending_entry_type entry;
      if ($urandom_range(0, 63) == 0) req_fast = !req_fast;
      gap = req_fast ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      entry.request = request;
      entry.typed = typed;
      entry.typed_rsp = typed_rsp;
      pending_reqs.push_back(entry);
      req_valid <= 1'b1;
      req_data <= request;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic logic [cspsc_pkg::VALUE_WIDTH-1:0] random_value();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return cspsc_pkg::VALUE_WIDTH'($urandom);
      endcase
   endfunction

   initial begin
      int results_taken;
      int gap;
      results_taken = 0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) rsp_fast = !rsp_fast;
         if (results_taken == 150 || results_taken == 900) gap = 300;
         else gap = rsp_fast ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         results_taken++;
         @(negedge clock);
      end
   end

   initial begin
      cspsc_pkg::req_type request;
      cspsc_pkg::rsp_type typed_rsp;
      int                 random_sent;
      int                 mode;
      int                 seg_len;
      int                 pick;
      int                 produce_lim;
      int                 flush_lim;
      int                 consume_lim;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_steps[i]) begin
         request.op = directed_steps[i].op;
         request.value = directed_steps[i].value;
         typed_rsp.status = directed_steps[i].status;
         typed_rsp.read_value = directed_steps[i].read_value;
         send_request(request, directed_steps[i].typed, typed_rsp);
      end

      // fill both producer and handoff chunks, then drain them
      for (int i = 0; i < BURST_LEN; i++) begin
         request.op = cspsc_pkg::OP_PRODUCE;
         request.value = random_value();
         send_request(request, 1'b0, '0);
      end
      for (int i = 0; i < BURST_LEN; i++) begin
         request.op = cspsc_pkg::OP_CONSUME;
         request.value = random_value();
         send_request(request, 1'b0, '0);
      end
      random_sent = 2 * BURST_LEN;

      while (random_sent < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         seg_len = $urandom_range(20, 200);
         case (mode)
            0: begin produce_lim = 80; flush_lim = 88; consume_lim = 99; end
            1: begin produce_lim = 20; flush_lim = 25; consume_lim = 99; end
            default: begin produce_lim = 45; flush_lim = 53; consume_lim = 99; end
         endcase
         for (int i = 0; i < seg_len && random_sent < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < produce_lim) request.op = cspsc_pkg::OP_PRODUCE;
            else if (pick < flush_lim) request.op = cspsc_pkg::OP_FLUSH;
            else if (pick < consume_lim) request.op = cspsc_pkg::OP_CONSUME;
            else request.op = OP_UNUSED;
            request.value = random_value();
            send_request(request, 1'b0, '0);
            random_sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
